// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/arsp_pkg.sv =====
// ----------------------------------------------------------------------------
// arsp_pkg
// Types, codes and constants of the ar archive stream parser.
// ----------------------------------------------------------------------------
package arsp_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_CONTENT = 3'd2;
  localparam logic [2:0] PH_PAD     = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  // Byte kind codes
  localparam logic [2:0] KIND_MAGIC   = 3'd0;
  localparam logic [2:0] KIND_NAME    = 3'd1;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_CONTENT = 3'd3;
  localparam logic [2:0] KIND_PAD     = 3'd4;
  localparam logic [2:0] KIND_DISCARD = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_END   = 2'd2;

  // Header layout
  localparam int SIZE_DIGITS  = 10;
  localparam logic [5:0] NAME_BYTES   = 6'd16;
  localparam logic [5:0] SIZE_OFFSET  = 6'd48;
  localparam logic [5:0] SIZE_LIMIT   = 6'(48 + SIZE_DIGITS);
  localparam logic [5:0] END_OFFSET   = 6'd58;
  localparam logic [5:0] LAST_OFFSET  = 6'd59;
  localparam logic [5:0] MAGIC_LAST   = 6'd7;

  // Characters
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_GRAVE   = 8'h60;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam int SIZE_W = 34;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        data;
    logic              header_done;
    logic [SIZE_W-1:0] size;
    logic [4:0]        name_len;
    logic              member_end;
    logic [1:0]        status;
  } result_t;

  // Global magic "!<arch>\n", one byte per position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h21;
      3'd1: b = 8'h3C;
      3'd2: b = 8'h61;
      3'd3: b = 8'h72;
      3'd4: b = 8'h63;
      3'd5: b = 8'h68;
      3'd6: b = 8'h3E;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/ar_archive_stream_parser.sv =====
// Each accepted item's result is registered. Throughput: one byte per cycle while
// the skid stage is empty; the per-byte path is one 34-bit multiply-by-ten add or
// one 34-bit decrement between the parser state and the result register.
// A one-entry skid stage takes one more item while the output is stalled.
// Reset: parser returns to expecting the global magic, check_pad_byte becomes 1,
// and both output stages are emptied.
// ----------------------------------------------------------------------------
// ar_archive_stream_parser
// Streaming Unix ar archive parser: tags each byte and reports member headers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ar_archive_stream_parser
  import arsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        archive_byte,
  input  logic              stream_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        byte_kind,
  output logic [7:0]        byte_out,
  output logic              header_done,
  output logic [SIZE_W-1:0] member_size,
  output logic [4:0]        name_length,
  output logic              member_end,
  output logic [1:0]        status
);

  // Parser state
  logic              check_pad_byte;
  logic [2:0]        phase, phase_next;
  logic [5:0]        hpos, hpos_next;
  logic [SIZE_W-1:0] size_acc, size_acc_next;
  logic              size_closed, size_closed_next;
  logic [SIZE_W-1:0] content_rem, content_rem_next;
  logic              pad_pend, pad_pend_next;
  logic [4:0]        ns_end, ns_end_next;
  logic              ns_slash, ns_slash_next;

  // Output stages
  logic    skid_valid;
  result_t out_res, skid_res, res;

  logic accept;
  logic err;

  // Header-start view of the per-member registers
  logic [SIZE_W-1:0] acc_cur;
  logic              closed_cur;
  logic [4:0]        ns_end_cur;
  logic              ns_slash_cur;
  logic [SIZE_W-1:0] rem_after;
  logic              is_digit;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // Compute next state and result for one byte
  always_comb begin
    phase_next       = phase;
    hpos_next        = hpos;
    size_acc_next    = size_acc;
    size_closed_next = size_closed;
    content_rem_next = content_rem;
    pad_pend_next    = pad_pend;
    ns_end_next      = ns_end;
    ns_slash_next    = ns_slash;
    err              = 1'b0;

    res             = '0;
    res.kind        = KIND_DISCARD;
    res.data        = archive_byte;

    acc_cur      = (hpos == 6'd0) ? '0 : size_acc;
    closed_cur   = (hpos == 6'd0) ? 1'b0 : size_closed;
    ns_end_cur   = (hpos == 6'd0) ? 5'd0 : ns_end;
    ns_slash_cur = (hpos == 6'd0) ? 1'b0 : ns_slash;
    rem_after    = (content_rem != '0) ? content_rem - 1'b1 : '0;
    is_digit     = (archive_byte >= CHAR_ZERO) && (archive_byte <= CHAR_NINE);

    unique case (phase)
      PH_MAGIC: begin
        res.kind = KIND_MAGIC;
        if (hpos > MAGIC_LAST || archive_byte != magic_byte(hpos[2:0])) begin
          err = 1'b1;
        end else if (hpos == MAGIC_LAST) begin
          phase_next = PH_HEADER;
          hpos_next  = 6'd0;
        end else begin
          hpos_next = hpos + 6'd1;
        end
      end
      PH_HEADER: begin
        size_acc_next    = acc_cur;
        size_closed_next = closed_cur;
        ns_end_next      = ns_end_cur;
        ns_slash_next    = ns_slash_cur;
        res.kind = (hpos < NAME_BYTES) ? KIND_NAME : KIND_HEADER;
        // Track the last non-space name character
        if (hpos < NAME_BYTES) begin
          if (archive_byte != CHAR_SPACE) begin
            ns_end_next   = hpos[4:0] + 5'd1;
            ns_slash_next = (archive_byte == CHAR_SLASH);
          end
        end else if (hpos >= SIZE_OFFSET && hpos < SIZE_LIMIT) begin
          // Accumulate decimal size until a space
          if (!closed_cur) begin
            if (is_digit) begin
              size_acc_next = (acc_cur << 3) + (acc_cur << 1)
                              + SIZE_W'(archive_byte - CHAR_ZERO);
            end else if (archive_byte == CHAR_SPACE) begin
              size_closed_next = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
        end else if (hpos == END_OFFSET) begin
          err = (archive_byte != CHAR_GRAVE);
        end else if (hpos == LAST_OFFSET) begin
          err = (archive_byte != CHAR_NEWLINE);
        end else if (hpos > LAST_OFFSET) begin
          err = 1'b1;
        end
        if (!err) begin
          if (hpos == LAST_OFFSET) begin
            res.header_done  = 1'b1;
            res.size         = acc_cur;
            res.name_len     = ns_end_next - 5'(ns_slash_next);
            content_rem_next = acc_cur;
            pad_pend_next    = acc_cur[0];
            hpos_next        = 6'd0;
            if (acc_cur == '0) begin
              res.member_end = 1'b1;
            end else begin
              phase_next = PH_CONTENT;
            end
          end else begin
            hpos_next = hpos + 6'd1;
          end
        end
      end
      PH_CONTENT: begin
        res.kind         = KIND_CONTENT;
        content_rem_next = rem_after;
        if (rem_after == '0) begin
          if (pad_pend) begin
            phase_next = PH_PAD;
          end else begin
            res.member_end = 1'b1;
            phase_next     = PH_HEADER;
            hpos_next      = 6'd0;
          end
        end
      end
      PH_PAD: begin
        res.kind = KIND_PAD;
        if (check_pad_byte && archive_byte != CHAR_NEWLINE) begin
          err = 1'b1;
        end else begin
          res.member_end = 1'b1;
          pad_pend_next  = 1'b0;
          phase_next     = PH_HEADER;
          hpos_next      = 6'd0;
        end
      end
      default: begin
        res.kind = KIND_DISCARD;
      end
    endcase

    // Resolve status, restart on the last byte, drop into discard on error
    if (res.kind != KIND_DISCARD) begin
      if (err) begin
        res.status = STATUS_ERROR;
      end else if (stream_last) begin
        res.status = (phase_next == PH_HEADER && hpos_next == 6'd0) ? STATUS_END
                                                                     : STATUS_ERROR;
      end
      if (!stream_last && err) begin
        phase_next = PH_DISCARD;
      end
    end
    if (stream_last) begin
      phase_next       = PH_MAGIC;
      hpos_next        = 6'd0;
      size_acc_next    = '0;
      size_closed_next = 1'b0;
      content_rem_next = '0;
      pad_pend_next    = 1'b0;
      ns_end_next      = 5'd0;
      ns_slash_next    = 1'b0;
    end
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      hpos        <= 6'd0;
      size_acc    <= '0;
      size_closed <= 1'b0;
      content_rem <= '0;
      pad_pend    <= 1'b0;
      ns_end      <= 5'd0;
      ns_slash    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      hpos        <= hpos_next;
      size_acc    <= size_acc_next;
      size_closed <= size_closed_next;
      content_rem <= content_rem_next;
      pad_pend    <= pad_pend_next;
      ns_end      <= ns_end_next;
      ns_slash    <= ns_slash_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      check_pad_byte <= 1'b1;
    end else if (cfg_we) begin
      check_pad_byte <= cfg_wdata;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid stage payload
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign byte_kind   = out_res.kind;
  assign byte_out    = out_res.data;
  assign header_done = out_res.header_done;
  assign member_size = out_res.size;
  assign name_length = out_res.name_len;
  assign member_end  = out_res.member_end;
  assign status      = out_res.status;

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid, "skid holds item with empty output")
  `ASSERT_ALWAYS(a_content_nonzero, phase != PH_CONTENT || content_rem != '0, "content phase with zero count")
  `ASSERT_ALWAYS(a_hpos_range, (phase != PH_MAGIC || hpos <= MAGIC_LAST) && (phase != PH_HEADER || hpos <= LAST_OFFSET), "header position out of range")
  `ASSERT_NEXT(a_last_restarts, accept && stream_last, phase == PH_MAGIC && hpos == 6'd0, "no restart after last byte")
  `ASSERT_ALWAYS(a_done_kind, !(out_valid && out_res.header_done) || out_res.kind == KIND_HEADER, "header done on wrong byte kind")

endmodule

// ===== tb/sv/tb_ar_archive_stream_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ar_archive_stream_parser
// Self-checking bench for the ar archive stream parser. Byte streams are
// driven through the valid/stall handshake: short directed archives first,
// then random archives, mostly well formed with some corrupted, truncated or
// pure noise. A byte-level parser model predicts the tag of every accepted
// byte, and each result is compared in order against it. The pad check
// setting and the sender and receiver idling change from phase to phase.
// ----------------------------------------------------------------------------

import arsp_pkg::*;

// Global magic "!<arch>\n", first byte in the top bits
localparam logic [63:0] AR_MAGIC = 64'h213C_6172_6368_3E0A;

typedef struct packed {
  logic [7:0] data;
  logic       last;
} ar_item_t;

// Tracks the parser state per byte and holds the tags still to come out
class ar_byte_scoreboard;
  logic              check_pad;
  logic [2:0]        phase;
  logic [5:0]        hdr_pos;
  logic [SIZE_W-1:0] size_acc;
  logic              size_closed;
  logic [SIZE_W-1:0] content_left;
  logic              pad_due;
  logic [4:0]        name_end;
  logic              name_slash;
  result_t           expected_tags[$];
  int                errors;
  int                parsed;

  function new();
    restart();
    check_pad = 1'b1;
    errors = 0;
    parsed = 0;
  endfunction

  function void restart();
    phase = PH_MAGIC;
    hdr_pos = '0;
    size_acc = '0;
    size_closed = 1'b0;
    content_left = '0;
    pad_due = 1'b0;
    name_end = '0;
    name_slash = 1'b0;
  endfunction

  // Advance the parser by one accepted byte and queue the tag it causes
  function void predict_byte(logic [7:0] b, logic last);
    result_t    r;
    logic       err;
    logic [5:0] pos;
    r = '0;
    r.data = b;
    r.kind = KIND_DISCARD;
    err = 1'b0;
    pos = hdr_pos;
    case (phase)
      PH_MAGIC: begin
        r.kind = KIND_MAGIC;
        if (pos > MAGIC_LAST || b != AR_MAGIC[63 - 8 * pos[2:0] -: 8]) begin
          err = 1'b1;
        end else if (pos == MAGIC_LAST) begin
          phase = PH_HEADER;
          hdr_pos = '0;
        end else begin
          hdr_pos = pos + 6'd1;
        end
      end
      PH_HEADER: begin
        if (pos == 0) begin
          size_acc = '0;
          size_closed = 1'b0;
          name_end = '0;
          name_slash = 1'b0;
        end
        r.kind = (pos < NAME_BYTES) ? KIND_NAME : KIND_HEADER;
        if (pos < NAME_BYTES) begin
          if (b != CHAR_SPACE) begin
            name_end = 5'(pos + 6'd1);
            name_slash = (b == CHAR_SLASH);
          end
        end else if (pos >= SIZE_OFFSET && pos < SIZE_LIMIT) begin
          if (!size_closed) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE)
              size_acc = size_acc * 34'd10 + SIZE_W'(b - CHAR_ZERO);
            else if (b == CHAR_SPACE)
              size_closed = 1'b1;
            else
              err = 1'b1;
          end
        end else if (pos == END_OFFSET) begin
          err = (b != CHAR_GRAVE);
        end else if (pos == LAST_OFFSET) begin
          err = (b != CHAR_NEWLINE);
        end else if (pos > LAST_OFFSET) begin
          err = 1'b1;
        end
        if (!err) begin
          if (pos == LAST_OFFSET) begin
            r.header_done = 1'b1;
            r.size = size_acc;
            r.name_len = name_end - 5'(name_slash);
            content_left = size_acc;
            pad_due = size_acc[0];
            hdr_pos = '0;
            if (size_acc == 0)
              r.member_end = 1'b1;
            else
              phase = PH_CONTENT;
          end else begin
            hdr_pos = pos + 6'd1;
          end
        end
      end
      PH_CONTENT: begin
        r.kind = KIND_CONTENT;
        if (content_left != 0)
          content_left = content_left - 1'b1;
        if (content_left == 0) begin
          if (pad_due) begin
            phase = PH_PAD;
          end else begin
            r.member_end = 1'b1;
            phase = PH_HEADER;
            hdr_pos = '0;
          end
        end
      end
      PH_PAD: begin
        r.kind = KIND_PAD;
        if (check_pad && b != CHAR_NEWLINE) begin
          err = 1'b1;
        end else begin
          r.member_end = 1'b1;
          pad_due = 1'b0;
          phase = PH_HEADER;
          hdr_pos = '0;
        end
      end
      default: begin
        if (last)
          restart();
      end
    endcase

    // Status and stream restart apply to every byte that is not discarded
    if (r.kind != KIND_DISCARD) begin
      if (err)
        r.status = STATUS_ERROR;
      else if (last)
        r.status = (phase == PH_HEADER && hdr_pos == 0) ? STATUS_END : STATUS_ERROR;
      if (last)
        restart();
      else if (err)
        phase = PH_DISCARD;
      parsed++;
    end
    expected_tags.push_back(r);
  endfunction

  // Compare one result against the oldest queued tag
  function void check_tag(logic [2:0] kind, logic [7:0] data, logic hd,
                          logic [SIZE_W-1:0] size, logic [4:0] nlen,
                          logic mend, logic [1:0] st);
    result_t exp;
    if (expected_tags.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR %0t: result with nothing expected, kind %0d byte %02h",
                 $time, kind, data);
      return;
    end
    exp = expected_tags.pop_front();
    if (kind !== exp.kind || data !== exp.data || hd !== exp.header_done ||
        size !== exp.size || nlen !== exp.name_len || mend !== exp.member_end ||
        st !== exp.status) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR %0t (expected/actual): kind %0d/%0d byte %02h/%02h hdr %0b/%0b",
                 $time, exp.kind, kind, exp.data, data, exp.header_done, hd);
        $display("  size %0d/%0d name %0d/%0d end %0b/%0b status %0d/%0d",
                 exp.size, size, exp.name_len, nlen, exp.member_end, mend,
                 exp.status, st);
      end
    end
  endfunction
endclass

module tb_ar_archive_stream_parser;

  localparam int MAGIC_LEN   = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        archive_byte = '0;
  logic              stream_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        byte_kind;
  logic [7:0]        byte_out;
  logic              header_done;
  logic [SIZE_W-1:0] member_size;
  logic [4:0]        name_length;
  logic              member_end;
  logic [1:0]        status;

  ar_byte_scoreboard sb;
  ar_item_t          stream_q[$];
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  logic              hold_pending = 1'b0;
  logic              pad_check_now = 1'b1;

  ar_archive_stream_parser uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .archive_byte (archive_byte),
    .stream_last  (stream_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_kind    (byte_kind),
    .byte_out     (byte_out),
    .header_done  (header_done),
    .member_size  (member_size),
    .name_length  (name_length),
    .member_end   (member_end),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  // Check every result taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_tag(byte_kind, byte_out, header_done, member_size, name_length,
                   member_end, status);
  end

  // ---- Stream building ----

  function automatic void put(input logic [7:0] b);
    stream_q.push_back({b, 1'b0});
  endfunction

  function automatic void put_magic();
    int i;
    for (i = 0; i < MAGIC_LEN; i++)
      put(AR_MAGIC[63 - 8 * i -: 8]);
  endfunction

  // Member header: name of nlen bytes (optionally ending in a slash), random
  // middle fields, size in at least width decimal digits, then the end marker
  function automatic void put_header(input longint unsigned size, input int nlen,
                                     input logic slash, input int width);
    logic [7:0]      digits[10];
    int              nd;
    int              w;
    int              i;
    logic            junk;
    longint unsigned v;
    logic [7:0]      c;
    for (i = 0; i < NAME_BYTES; i++) begin
      if (i < nlen) begin
        c = 8'($urandom_range(0, 255));
        if (i == nlen - 1)
          c = slash ? CHAR_SLASH : ((c == CHAR_SPACE) ? 8'h41 : c);
      end else begin
        c = CHAR_SPACE;
      end
      put(c);
    end
    for (i = NAME_BYTES; i < SIZE_OFFSET; i++)
      put(8'($urandom_range(0, 255)));
    nd = 0;
    v = size;
    while (v != 0 && nd < SIZE_DIGITS) begin
      digits[nd] = CHAR_ZERO + 8'(v % 10);
      v = v / 10;
      nd++;
    end
    w = (width < nd) ? nd : width;
    for (i = w - 1; i >= 0; i--)
      put((i < nd) ? digits[i] : CHAR_ZERO);
    // Bytes after the closing space are not checked
    junk = ($urandom_range(0, 3) == 0);
    for (i = SIZE_OFFSET + w; i < END_OFFSET; i++)
      put((i == SIZE_OFFSET + w || !junk) ? CHAR_SPACE : 8'($urandom_range(0, 255)));
    put(CHAR_GRAVE);
    put(CHAR_NEWLINE);
  endfunction

  function automatic void put_body(input longint unsigned size, input logic [7:0] pad);
    longint unsigned n;
    for (n = 0; n < size; n++)
      put(8'($urandom_range(0, 255)));
    if (size[0])
      put(pad);
  endfunction

  function automatic logic [7:0] random_pad();
    if (pad_check_now)
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CHAR_NEWLINE;
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : CHAR_NEWLINE;
  endfunction

  // Random archive: mostly well formed, some corrupted, truncated or noise
  function automatic void build_random_archive();
    int              pick;
    int              nmem;
    int              m;
    int              idx;
    int              cut;
    longint unsigned size;
    logic            stop;
    stream_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      nmem = $urandom_range(1, 24);
      for (m = 0; m < nmem; m++)
        put(8'($urandom_range(0, 255)));
      return;
    end
    put_magic();
    nmem = $urandom_range(0, 3);
    stop = 1'b0;
    for (m = 0; m < nmem && !stop; m++) begin
      if ($urandom_range(0, 49) == 0) begin
        // Huge size: send a few content bytes and end the stream early
        size = {$urandom, $urandom} % 64'd10000000000;
        put_header(size, $urandom_range(0, 16), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 10));
        put_body($urandom_range(0, 5), CHAR_NEWLINE);
        stop = 1'b1;
      end else begin
        size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
        put_header(size, $urandom_range(0, 16), $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0);
        put_body(size, random_pad());
      end
    end
    if (pick < 17) begin
      case ($urandom_range(0, 3))
        0:       idx = $urandom_range(0, stream_q.size() - 1);
        1:       idx = $urandom_range(0, MAGIC_LEN - 1);
        2:       idx = MAGIC_LEN + SIZE_OFFSET;
        default: idx = MAGIC_LEN + $urandom_range(END_OFFSET, LAST_OFFSET);
      endcase
      if (idx < stream_q.size())
        stream_q[idx].data = 8'($urandom_range(0, 255));
    end else if (pick < 25) begin
      cut = $urandom_range(1, stream_q.size());
      while (stream_q.size() > cut)
        void'(stream_q.pop_back());
    end
  endfunction

  // ---- Driving ----

  // Offer one item after a random gap and hold it until it is taken
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    archive_byte <= b;
    stream_last <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.predict_byte(b, last);
    @(negedge clk);
  endtask

  // Mark the final byte and send the whole stream
  task automatic play_stream();
    stream_q[stream_q.size() - 1].last = 1'b1;
    foreach (stream_q[i])
      send_item(stream_q[i].data, stream_q[i].last);
    stream_q.delete();
  endtask

  // Stop offering and wait until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_tags.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_pad_check(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.check_pad = v;
    pad_check_now = v;
  endtask

  task automatic run_directed();
    // Magic alone is a clean empty archive
    put_magic();
    play_stream();
    // Bad first magic byte, rest discarded
    put(8'h3F);
    put(8'h3C);
    put(8'h00);
    put(8'hFF);
    play_stream();
    // Empty member ends the archive on its last header byte
    put_magic();
    put_header(0, 2, 1'b1, 1);
    play_stream();
    // Odd member with pad, then a member named by a lone slash
    put_magic();
    put_header(3, 16, 1'b0, 0);
    put_body(3, CHAR_NEWLINE);
    put_header(2, 1, 1'b1, 0);
    put_body(2, CHAR_NEWLINE);
    play_stream();
    // Non-digit in the size field
    put_magic();
    put_header(5, 4, 1'b0, 0);
    put_body(5, CHAR_NEWLINE);
    stream_q[MAGIC_LEN + SIZE_OFFSET].data = 8'h78;
    play_stream();
    // Bad end marker, first byte then second byte
    put_magic();
    put_header(2, 3, 1'b0, 0);
    put_body(2, CHAR_NEWLINE);
    stream_q[MAGIC_LEN + END_OFFSET].data = 8'h61;
    play_stream();
    put_magic();
    put_header(2, 3, 1'b0, 0);
    put_body(2, CHAR_NEWLINE);
    stream_q[MAGIC_LEN + LAST_OFFSET].data = 8'h0D;
    play_stream();
    // Bad pad byte with the check on, next member discarded
    put_magic();
    put_header(1, 5, 1'b0, 0);
    put_body(1, 8'h00);
    put_header(0, 1, 1'b0, 0);
    play_stream();
    // Largest size, stream cut inside the content
    put_magic();
    put_header(64'd9999999999, 16, 1'b1, 10);
    put_body(4, CHAR_NEWLINE);
    play_stream();
    // Size with leading zeros filling the field, extreme content bytes
    put_magic();
    put_header(4, 0, 1'b0, 10);
    put(8'h00);
    put(8'hFF);
    put(8'h00);
    put(8'hFF);
    play_stream();
    // Magic cut short
    put(8'h21);
    put(8'h3C);
    put(8'h61);
    play_stream();
    // Empty size field, then a member ending the stream on its pad
    put_magic();
    put_header(0, 0, 1'b0, 0);
    put_header(7, 8, 1'b0, 1);
    put_body(7, CHAR_NEWLINE);
    play_stream();
  endtask

  initial begin : main
    int ph;
    int target;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          write_pad_check(1'b1);
        end
        1: begin
          sender_idle_pct = 78;
          receiver_stall_pct = 0;
          write_pad_check(1'b0);
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 78;
          write_pad_check(1'b1);
          hold_pending = 1'b1;
        end
        default: begin
          sender_idle_pct = 17;
          receiver_stall_pct = 17;
          write_pad_check(1'b0);
        end
      endcase
      target = sb.parsed + PHASE_ITEMS;
      while (sb.parsed < target) begin
        build_random_archive();
        play_stream();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tags.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
